/* rtl/cesd_pkg.sv */
// Package for the C string escape sequence decoder.
// Holds the word types, the decoder mode enum, character constants and helpers.
// No dependencies.
package cesd_pkg;

  // One raw byte of the escaped string.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } cesd_in_t;

  // One decoded byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_string;
  } cesd_out_t;

  // Decoder mode. The unused code is handled as plain text.
  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } cesd_mode_t;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QMARK     = 8'h3F;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [1:0] HEX_BYTES      = 2'd3;
  localparam logic [4:0] HEX_NONE       = 5'd16;

  // Digit value 0..15 of a hex character, or HEX_NONE when it is not one.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = HEX_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // Lower and upper case letters share the low three bits.
      d = 5'd9 + {2'b00, c[2:0]};
    end
    return d;
  endfunction

  // Character that follows a backslash, mapped to its decoded byte.
  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] m;
    unique case (c)
      8'h30:   m = 8'h00;  // 0
      8'h61:   m = 8'h07;  // a
      8'h62:   m = 8'h08;  // b
      8'h66:   m = 8'h0C;  // f
      8'h6E:   m = 8'h0A;  // n
      8'h72:   m = 8'h0D;  // r
      8'h74:   m = 8'h09;  // t
      8'h76:   m = 8'h0B;  // v
      default: m = c;      // quote, apostrophe, backslash, question mark, others
    endcase
    return m;
  endfunction

endpackage

/* rtl/c_escape_sequence_decoder_top.sv */
// Top level of the C string escape sequence decoder.
// Depends on cesd_pkg for word types, mode enum, constants and helper functions.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one raw byte of an
//   escaped string per word, with end_of_string set on the string's last byte.
//   The output channel (out_valid, out_ready, out_data) gives decoded bytes,
//   with last_of_string set on the final decoded byte of each string. Every
//   string ends with exactly one word flagged last.
//   A byte is captured in an input register, decoded against the mode and
//   hex registers once the output register can take a word, and any result
//   lands in the output register.
//   One byte is taken every cycle while the receiver does not stall; the only
//   loop is the update of the mode and hex registers.
//   Bytes that start an escape or sit inside a hex escape give no word.
//   When the receiver stalls, the output register holds its word and the
//   input register holds the next byte; in_ready falls only once both are full.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   decoder to plain text mode with the hex state cleared.
module c_escape_sequence_decoder_top
  import cesd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cesd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cesd_out_t out_data
);

  logic       in_valid_r;
  cesd_in_t   in_data_r;
  logic       out_valid_r;
  cesd_out_t  out_data_r;

  cesd_mode_t mode_r, mode_nxt;
  logic [1:0] hex_count_r, hex_count_nxt;
  logic [7:0] hex_value_r, hex_value_nxt;
  logic       hex_stopped_r, hex_stopped_nxt;

  logic       out_free;
  logic       step;
  logic       emit;
  cesd_out_t  result;

  logic [7:0] c;
  logic       last;
  logic [4:0] digit;
  logic       take_digit;
  logic [7:0] hex_acc;
  logic [1:0] hex_count_inc;

  // Handshake: the decode step runs when the output register can take a word.
  assign out_free  = !out_valid_r || out_ready;
  assign step      = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared decode terms.
  assign c             = in_data_r.in_byte;
  assign last          = in_data_r.end_of_string;
  assign digit         = hex_digit(c);
  assign take_digit    = !hex_stopped_r && (digit != HEX_NONE);
  assign hex_acc       = take_digit ? {hex_value_r[3:0], digit[3:0]} : hex_value_r;
  assign hex_count_inc = hex_count_r + 2'd1;

  // Next state of the decoder.
  always_comb begin
    mode_nxt        = MODE_PLAIN;
    hex_count_nxt   = 2'd0;
    hex_value_nxt   = 8'd0;
    hex_stopped_nxt = 1'b0;
    unique case (mode_r)
      MODE_ESCAPE: begin
        if (c == CHAR_X && !last) begin
          mode_nxt = MODE_HEX;
        end
      end
      MODE_HEX: begin
        if (!(hex_count_inc == HEX_BYTES || last)) begin
          mode_nxt        = MODE_HEX;
          hex_count_nxt   = hex_count_inc;
          hex_value_nxt   = hex_acc;
          hex_stopped_nxt = hex_stopped_r || !take_digit;
        end
      end
      default: begin
        if (c == CHAR_BACKSLASH && !last) begin
          mode_nxt = MODE_ESCAPE;
        end
      end
    endcase
  end

  // Result of the decode step.
  always_comb begin
    emit                  = 1'b1;
    result.out_byte       = c;
    result.last_of_string = last;
    unique case (mode_r)
      MODE_ESCAPE: begin
        if (c == CHAR_X) begin
          emit            = last;
          result.out_byte = 8'd0;
        end else begin
          result.out_byte = map_escape(c);
        end
      end
      MODE_HEX: begin
        emit            = (hex_count_inc == HEX_BYTES) || last;
        result.out_byte = hex_acc;
      end
      default: begin
        emit = !(c == CHAR_BACKSLASH && !last);
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      mode_r        <= MODE_PLAIN;
      hex_count_r   <= 2'd0;
      hex_value_r   <= 8'd0;
      hex_stopped_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= step && emit;
      end
      if (step) begin
        mode_r        <= mode_nxt;
        hex_count_r   <= hex_count_nxt;
        hex_value_r   <= hex_value_nxt;
        hex_stopped_r <= hex_stopped_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (step && emit) begin
      out_data_r <= result;
    end
  end

endmodule
